/* hw/rtl/ept_pkg.sv */
`default_nettype none
package ept_pkg;

  localparam int DIVIDEND_W = 32;
  localparam int SPEED_W    = 16;
  localparam int GAP_W      = 20;
  localparam int COUNT_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_CONST = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_LEVEL  = 3'd3;

  localparam logic [DIVIDEND_W-1:0] SPEED_CONST_RST = 32'd60000000;
  localparam logic [GAP_W-1:0]      MIN_GAP_RST     = 20'd1000;
  localparam logic [SPEED_W-1:0]    MAX_SPEED_RST   = 16'd10000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_OUT
  } ept_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ept_div_stat_t;

endpackage
`default_nettype wire

/* hw/rtl/edge_period_tachometer_top.sv */
`default_nettype none
// Tachometer: one result per tick transfer.
// When a divide runs, a tick passes through divisor select, 32 steps of the
// divider, clamp and output load; before the first edge or on a zero divisor
// the divide is skipped.
// A new tick is taken only after the last result is loaded; a held result stalls.
// Reset: synchronous active-low rst_n restores register defaults, clears time and counts.
module edge_period_tachometer_top
  import ept_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_pin_level,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [SPEED_W-1:0]         out_speed,
  output logic                       out_edge_accepted,
  output logic [COUNT_W-1:0]         out_edge_count
);

  localparam int CW = (TIME_BITS > GAP_W) ? TIME_BITS : GAP_W;

  ept_state_t state_r, state_nxt;

  logic [DIVIDEND_W-1:0] speed_const_r;
  logic [GAP_W-1:0]      min_gap_r;
  logic [SPEED_W-1:0]    max_speed_r;
  logic                  sensor_r;

  logic [TIME_BITS-1:0]  time_now_r;
  logic [TIME_BITS-1:0]  last_edge_r;
  logic [TIME_BITS-1:0]  last_period_r;
  logic [TIME_BITS-1:0]  since_r;
  logic [COUNT_W-1:0]    edges_r;
  logic                  edge_seen_r;
  logic                  acc_r;
  logic [SPEED_W-1:0]    speed_r;

  logic                  out_valid_r;
  logic [SPEED_W-1:0]    out_speed_r;
  logic                  out_acc_r;
  logic [COUNT_W-1:0]    out_count_r;

  logic                  in_xfer;
  logic [TIME_BITS-1:0]  since;
  logic                  edge_ok;
  logic [TIME_BITS-1:0]  div_val;
  logic                  div_zero;
  logic                  div_start;
  logic                  out_load;
  ept_div_stat_t         dstat;
  logic [DIVIDEND_W-1:0] quo;

  assign in_xfer  = in_valid && in_ready;
  assign since    = time_now_r - last_edge_r;
  assign edge_ok  = (in_pin_level != sensor_r) && (CW'(since) > CW'(min_gap_r));
  assign div_val  = (since_r > last_period_r) ? since_r : last_period_r;
  assign div_zero = (div_val == '0);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_PREP;
      ST_PREP: state_nxt = (!edge_seen_r || div_zero) ? ST_OUT : ST_DIV;
      ST_DIV:  if (dstat.done) state_nxt = ST_OUT;
      ST_OUT:  if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: in_ready  = 1'b1;
      ST_PREP: div_start = edge_seen_r && !div_zero;
      ST_DIV:  ;
      ST_OUT:  out_load  = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_const_r <= SPEED_CONST_RST;
      min_gap_r     <= MIN_GAP_RST;
      max_speed_r   <= MAX_SPEED_RST;
      sensor_r      <= 1'b0;
      time_now_r    <= '0;
      last_edge_r   <= '0;
      last_period_r <= '0;
      edges_r       <= '0;
      edge_seen_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SPEED_CONST: speed_const_r <= cfg_wdata;
          CFG_MIN_GAP:     min_gap_r     <= cfg_wdata[GAP_W-1:0];
          CFG_MAX_SPEED:   max_speed_r   <= cfg_wdata[SPEED_W-1:0];
          CFG_INIT_LEVEL:  sensor_r      <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_xfer) begin
        time_now_r <= time_now_r + 1'b1;
        if (edge_ok) begin
          sensor_r      <= in_pin_level;
          last_period_r <= since;
          last_edge_r   <= time_now_r;
          edges_r       <= edges_r + 1'b1;
          edge_seen_r   <= 1'b1;
        end
      end
    end
  end

  // tick payload; after an accepted edge since_r equals the new period, so period == since then
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      since_r <= since;
      acc_r   <= edge_ok;
    end
    if (state_r == ST_PREP) begin
      speed_r <= edge_seen_r ? max_speed_r : '0;
    end else if (state_r == ST_DIV && dstat.done) begin
      speed_r <= (quo > DIVIDEND_W'(max_speed_r)) ? max_speed_r : quo[SPEED_W-1:0];
    end
  end

  ept_div #(
    .DW(TIME_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (speed_const_r),
    .divisor  (div_val),
    .stat     (dstat),
    .quotient (quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_speed_r <= speed_r;
      out_acc_r   <= acc_r;
      out_count_r <= edges_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_speed         = out_speed_r;
  assign out_edge_accepted = out_acc_r;
  assign out_edge_count    = out_count_r;

endmodule
`default_nettype wire

/* hw/rtl/ept_div.sv */
`default_nettype none
module ept_div
  import ept_pkg::*;
#(
  parameter int DW = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [DIVIDEND_W-1:0] dividend,
  input  wire logic [DW-1:0]         divisor,
  output ept_div_stat_t              stat,
  output logic [DIVIDEND_W-1:0]      quotient
);

  localparam int RW  = ((DW > DIVIDEND_W) ? DW : DIVIDEND_W) + 1;
  localparam int CNW = $clog2(DIVIDEND_W);

  logic [RW-1:0]         rem_r, rem_nxt;
  logic [DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [DW-1:0]         dv_r;
  logic [CNW-1:0]        cnt_r;
  logic                  busy_r, done_r;

  logic [RW-1:0] shifted;
  logic [RW-1:0] dv_ext;
  logic          fits;

  // one restoring step per cycle while busy
  always_comb begin
    shifted = {rem_r[RW-2:0], quo_r[DIVIDEND_W-1]};
    dv_ext  = RW'(dv_r);
    fits    = (shifted >= dv_ext);
    rem_nxt = fits ? (shifted - dv_ext) : shifted;
    quo_nxt = {quo_r[DIVIDEND_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNW'(DIVIDEND_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dv_r  <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule
`default_nettype wire

/* tb/tach_speed_checker.sv */
`timescale 1ns / 100ps
module tach_speed_checker
  import ept_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_valid,
  input  wire logic                  in_ready,
  input  wire logic                  in_pin_level,
  input  wire logic                  out_valid,
  input  wire logic                  out_ready,
  input  wire logic [SPEED_W-1:0]    out_speed,
  input  wire logic                  out_edge_accepted,
  input  wire logic [COUNT_W-1:0]    out_edge_count,
  output int                         mismatch_count,
  output int                         pending_ticks
);

  localparam int TICK_W       = 32;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [SPEED_W-1:0] speed;
    logic               edge_hit;
    logic [COUNT_W-1:0] count;
  } tick_result_t;

  logic [DIVIDEND_W-1:0] k_speed;
  logic [GAP_W-1:0]      k_gap;
  logic [SPEED_W-1:0]    k_max;

  logic [TICK_W-1:0]     now_us;
  logic [TICK_W-1:0]     edge_us;
  logic [TICK_W-1:0]     period_us;
  logic [COUNT_W-1:0]    edges;
  logic                  level_q;
  logic                  seen;

  tick_result_t expected_ticks[$];

  task automatic predict_tick(input logic lvl, output tick_result_t r);
    logic [TICK_W-1:0]     since;
    logic [TICK_W-1:0]     divisor;
    logic [DIVIDEND_W-1:0] quot;
    since = now_us - edge_us;
    r = '0;
    if (lvl != level_q && since > TICK_W'(k_gap)) begin
      level_q    = lvl;
      period_us  = since;
      edges      = edges + 1'b1;
      edge_us    = now_us;
      seen       = 1'b1;
      r.edge_hit = 1'b1;
    end
    if (seen) begin
      since   = now_us - edge_us;
      divisor = (since > period_us) ? since : period_us;
      if (divisor == '0) begin
        r.speed = k_max;
      end else begin
        quot    = DIVIDEND_W'(k_speed / divisor);
        r.speed = (quot > DIVIDEND_W'(k_max)) ? k_max : quot[SPEED_W-1:0];
      end
    end
    r.count = edges;
    now_us  = now_us + 1'b1;
  endtask

  always @(posedge clk) begin
    tick_result_t got;
    tick_result_t want;
    if (!rst_n) begin
      k_speed   = SPEED_CONST_RST;
      k_gap     = MIN_GAP_RST;
      k_max     = MAX_SPEED_RST;
      now_us    = '0;
      edge_us   = '0;
      period_us = '0;
      edges     = '0;
      level_q   = 1'b0;
      seen      = 1'b0;
      expected_ticks.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SPEED_CONST: k_speed = cfg_wdata[DIVIDEND_W-1:0];
          CFG_MIN_GAP:     k_gap   = cfg_wdata[GAP_W-1:0];
          CFG_MAX_SPEED:   k_max   = cfg_wdata[SPEED_W-1:0];
          CFG_INIT_LEVEL:  level_q = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        predict_tick(in_pin_level, want);
        expected_ticks.push_back(want);
      end
      if (out_valid && out_ready) begin
        got = '{speed: out_speed, edge_hit: out_edge_accepted, count: out_edge_count};
        if (expected_ticks.size() == 0) begin
          if (mismatch_count < REPORT_LIMIT)
            $display("%0t: unexpected result transfer: speed %0d edge %0b count %0d",
                     $realtime, got.speed, got.edge_hit, got.count);
          mismatch_count++;
        end else begin
          want = expected_ticks.pop_front();
          if (got !== want) begin
            if (mismatch_count < REPORT_LIMIT)
              $display({"%0t: result mismatch: speed exp %0d got %0d, ",
                        "edge exp %0b got %0b, count exp %0d got %0d"},
                       $realtime, want.speed, got.speed, want.edge_hit, got.edge_hit,
                       want.count, got.count);
            mismatch_count++;
          end
        end
      end
    end
    pending_ticks <= expected_ticks.size();
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
module testbench;
  import ept_pkg::*;

  localparam int RESET_CYCLES  = 9;
  localparam int STALL_LIMIT   = 4000;
  localparam int DRAIN_CYCLES  = 40;
  localparam int IDLE_PCT      = 25;
  localparam int GAP_LEN_MAX   = 45;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_TICKS   = 125;

  localparam logic [CFG_IDX_W-1:0]  CFG_FIRST_UNUSED = CFG_INIT_LEVEL + 1'b1;
  localparam int                    UNUSED_SPAN = (1 << CFG_IDX_W) - 1 - CFG_FIRST_UNUSED;
  localparam logic [GAP_W-1:0]      GAP_MAX   = '1;
  localparam logic [SPEED_W-1:0]    SPEED_MAX = '1;
  localparam logic [DIVIDEND_W-1:0] CONST_MAX = '1;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_pin_level = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [SPEED_W-1:0]    out_speed;
  logic                  out_edge_accepted;
  logic [COUNT_W-1:0]    out_edge_count;

  logic no_idle = 1'b0;
  logic level_now = 1'b0;
  int   mismatch_count;
  int   pending_ticks;
  int   stall_cycles = 0;

  always #2 clk = ~clk;

  edge_period_tachometer_top u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_pin_level      (in_pin_level),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_speed         (out_speed),
    .out_edge_accepted (out_edge_accepted),
    .out_edge_count    (out_edge_count)
  );

  tach_speed_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_pin_level      (in_pin_level),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_speed         (out_speed),
    .out_edge_accepted (out_edge_accepted),
    .out_edge_count    (out_edge_count),
    .mismatch_count    (mismatch_count),
    .pending_ticks     (pending_ticks)
  );

  always @(posedge clk) begin
    if (no_idle) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // no-transfer watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_tick(input logic lvl);
    int gap_len;
    if (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      gap_len = $urandom_range(1, GAP_LEN_MAX);
      in_valid <= 1'b0;
      repeat (gap_len) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_pin_level <= lvl;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_ticks != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // level runs with occasional bounce ticks and pure noise ticks
  task automatic drive_pulses(input int n_ticks, input int run_lo, input int run_hi,
                              input int glitch_pct, input int noise_pct);
    int sent;
    int run;
    sent = 0;
    while (sent < n_ticks) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        send_tick(1'($urandom_range(0, 1)));
        sent++;
      end else begin
        run = $urandom_range(run_lo, run_hi);
        level_now = ~level_now;
        for (int i = 0; i < run && sent < n_ticks; i++) begin
          if (i > 0 && $urandom_range(0, 99) < glitch_pct) begin
            send_tick(~level_now);
          end else begin
            send_tick(level_now);
          end
          sent++;
        end
      end
    end
  endtask

  initial begin
    int gap;
    int run_lo;
    logic [DIVIDEND_W-1:0] k;
    logic [SPEED_W-1:0] top_speed;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: debounce rejects early toggles
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    wait_drained();

    // no debounce, widest constant: edge on every toggle, clamped speed
    cfg_write(CFG_MIN_GAP, '0);
    cfg_write(CFG_MAX_SPEED, CFG_DATA_W'(SPEED_MAX));
    cfg_write(CFG_SPEED_CONST, CONST_MAX);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
    wait_drained();

    cfg_write(CFG_MAX_SPEED, '0);
    send_tick(1'b0);
    send_tick(1'b1);
    wait_drained();

    cfg_write(CFG_MAX_SPEED, CFG_DATA_W'(SPEED_MAX));
    cfg_write(CFG_SPEED_CONST, '0);
    send_tick(1'b0);
    send_tick(1'b1);
    wait_drained();

    // level load from config, then writes to unused indexes
    cfg_write(CFG_INIT_LEVEL, CFG_DATA_W'(1));
    cfg_write(CFG_SPEED_CONST, CFG_DATA_W'(1000));
    send_tick(1'b1);
    send_tick(1'b0);
    wait_drained();
    for (int i = 0; i <= UNUSED_SPAN; i++)
      cfg_write(CFG_FIRST_UNUSED + CFG_IDX_W'(i), $urandom);
    send_tick(1'b1);
    wait_drained();

    // widest debounce: nothing accepted, speed decays with elapsed time
    cfg_write(CFG_MIN_GAP, CFG_DATA_W'(GAP_MAX));
    send_tick(1'b0);
    send_tick(1'b1);
    wait_drained();

    // gap boundary: equal to gap rejected, one more accepted
    cfg_write(CFG_MIN_GAP, CFG_DATA_W'(2));
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b0);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_drained();
      case (p)
        0: k = CONST_MAX;
        1: k = '0;
        default: begin
          if ($urandom_range(0, 2) == 0) k = $urandom;
          else k = $urandom_range(0, 2000000);
        end
      endcase
      if (p == 1 || $urandom_range(0, 3) == 0) top_speed = SPEED_MAX;
      else top_speed = SPEED_W'($urandom_range(0, 65535));
      gap = (p == 2) ? 0 : $urandom_range(0, 12);
      cfg_write(CFG_SPEED_CONST, k);
      cfg_write(CFG_MIN_GAP, ((CFG_DATA_W'($urandom) >> GAP_W) << GAP_W) | CFG_DATA_W'(gap));
      cfg_write(CFG_MAX_SPEED,
                ((CFG_DATA_W'($urandom) >> SPEED_W) << SPEED_W) | CFG_DATA_W'(top_speed));
      cfg_write(CFG_INIT_LEVEL, $urandom);
      if ($urandom_range(0, 1) == 1)
        cfg_write(CFG_FIRST_UNUSED + CFG_IDX_W'($urandom_range(0, UNUSED_SPAN)), $urandom);
      no_idle <= (p == 3);
      run_lo = ($urandom_range(0, 3) == 0) ? 1 : gap + 1;
      drive_pulses(PHASE_TICKS, run_lo, gap + 25, 5, 5);
    end
    wait_drained();
    no_idle <= 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_ticks == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/ept_pkg.sv
hw/rtl/ept_div.sv
hw/rtl/edge_period_tachometer_top.sv
tb/tach_speed_checker.sv
tb/testbench.sv
